/* src/mwu_pkg.sv */
// mwu_pkg: shared types and constants of the momentum weight update block
// no dependencies; imported by mwu_front, mwu_back and momentum_weight_update
`timescale 1ns / 1ps
`default_nettype none

package mwu_pkg;

    localparam int Q_W       = 16;   // signed Q4.12 data width
    localparam int FRAC      = 12;   // fraction bits of Q4.12 and Q0.12
    localparam int CFG_W     = 12;   // learn_rate and momentum width
    localparam int IDX_W     = 6;    // src_index and dst_index width
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] LEARN_RATE_RESET = 12'd1024;  // 0.25
    localparam logic [CFG_W-1:0] MOMENTUM_RESET   = 12'd1229;  // about 0.3

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic
    {
        CFG_LEARN_RATE = 1'b0,
        CFG_MOMENTUM   = 1'b1
    } cfg_reg_t;

    // one classified request as it travels from front to back
    typedef struct packed
    {
        op_t                    op;
        logic                   live;           // indexes inside the array
        logic signed [Q_W-1:0]  source_output;
        logic signed [Q_W-1:0]  gradient;
        logic signed [Q_W-1:0]  load_value;
    } item_t;

endpackage

`default_nettype wire

/* src/mwu_ram.sv */
// mwu_ram: generic single write port, single read port RAM with registered read
// no dependencies; read returns old data when the same address is written
`timescale 1ns / 1ps
`default_nettype none

module mwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/mwu_front.sv */
// mwu_front: takes requests, checks the connection indexes and forms the array address
// depends on mwu_pkg; feeds mwu_queue
`timescale 1ns / 1ps
`default_nettype none

module mwu_front #(
    parameter int MAX_SOURCES = 64,
    parameter int MAX_DESTS   = 64,
    parameter int ADDR_W      = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [mwu_pkg::IDX_W-1:0]           src_index,
    input  logic [mwu_pkg::IDX_W-1:0]           dst_index,
    input  logic signed [mwu_pkg::Q_W-1:0]      source_output,
    input  logic signed [mwu_pkg::Q_W-1:0]      gradient,
    input  logic signed [mwu_pkg::Q_W-1:0]      load_value,
    output logic                                push_valid,
    input  logic                                push_ready,
    output mwu_pkg::item_t                      push_item,
    output logic [ADDR_W-1:0]                   push_addr
);

    import mwu_pkg::*;

    logic              f_valid_reg;
    logic              f_valid_next;
    item_t             f_item_reg;
    logic [ADDR_W-1:0] f_addr_reg;
    logic              accept;
    logic              live;
    logic [ADDR_W-1:0] addr;

    assign busy   = f_valid_reg && !push_ready;
    assign accept = start && !busy;

    assign live = (32'(src_index) < MAX_SOURCES) && (32'(dst_index) < MAX_DESTS);
    // row-major: src_index * MAX_DESTS + dst_index
    assign addr = ADDR_W'(ADDR_W'(src_index) * ADDR_W'(MAX_DESTS)) + ADDR_W'(dst_index);

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg.op            <= op_t'(op);
            f_item_reg.live          <= live;
            f_item_reg.source_output <= source_output;
            f_item_reg.gradient      <= gradient;
            f_item_reg.load_value    <= load_value;
            f_addr_reg               <= addr;
        end
    end

    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;
    assign push_addr  = f_addr_reg;

endmodule

`default_nettype wire

/* src/mwu_queue.sv */
// mwu_queue: short first-in first-out queue between the front and the back
// no package dependency; width and depth set by parameters
`timescale 1ns / 1ps
`default_nettype none

module mwu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(DEPTH)) && !do_pop |=> (count_reg == CNT_W'(DEPTH)))
        else $error("queue lost an entry while full");
`endif

endmodule

`default_nettype wire

/* src/mwu_back.sv */
// mwu_back: update pipeline with weight/delta array, forwarding and result register
// depends on mwu_pkg and mwu_ram; takes requests from mwu_queue
`timescale 1ns / 1ps
`default_nettype none

module mwu_back #(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  mwu_pkg::item_t                  head_item,
    input  logic [ADDR_W-1:0]               head_addr,
    output logic                            head_pop,
    input  logic [mwu_pkg::CFG_W-1:0]       learn_rate,
    input  logic [mwu_pkg::CFG_W-1:0]       momentum,
    output logic                            done,
    output logic signed [mwu_pkg::Q_W-1:0]  weight,
    output logic signed [mwu_pkg::Q_W-1:0]  step_delta,
    output logic                            saturated
);

    import mwu_pkg::*;

    localparam int G_W        = 2 * Q_W - FRAC;          // source_output*gradient >> 12
    localparam int A_PROD_W   = G_W + CFG_W + 1;
    localparam int A_W        = A_PROD_W - FRAC;
    localparam int M_PROD_W   = Q_W + CFG_W + 1;
    localparam int M_W        = M_PROD_W - FRAC;
    localparam int SUM_W      = A_W + 1;
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed
    {
        op_t                    op;
        logic                   live;
        logic signed [Q_W-1:0]  load_value;
    } tag_t;

    typedef struct packed
    {
        logic                   clamped;
        logic signed [Q_W-1:0]  value;
    } sat_t;

    function automatic sat_t clamp16(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if (v > SUM_W'(Q_MAX))
        begin
            r.clamped = 1'b1;
            r.value   = Q_MAX;
        end
        else if (v < SUM_W'(Q_MIN))
        begin
            r.clamped = 1'b1;
            r.value   = Q_MIN;
        end
        else
        begin
            r.clamped = 1'b0;
            r.value   = v[Q_W-1:0];
        end
        return r;
    endfunction

    // stage 1: array read in flight, learn-rate product
    logic                        s1_valid_reg;
    tag_t                        s1_tag_reg;
    logic [ADDR_W-1:0]           s1_addr_reg;
    logic signed [G_W-1:0]       s1_g_reg;
    // stage 2: momentum product and new delta
    logic                        s2_valid_reg;
    tag_t                        s2_tag_reg;
    logic [ADDR_W-1:0]           s2_addr_reg;
    logic signed [A_W-1:0]       s2_a_reg;
    logic signed [Q_W-1:0]       s2_w_old_reg;
    logic signed [Q_W-1:0]       s2_d_old_reg;
    // stage 3: new weight, array write
    logic                        s3_valid_reg;
    tag_t                        s3_tag_reg;
    logic [ADDR_W-1:0]           s3_addr_reg;
    logic signed [Q_W-1:0]       s3_d_reg;
    logic                        s3_sat_reg;
    logic signed [Q_W-1:0]       s3_w_old_reg;
    // result and last written entry
    logic                        done_reg;
    logic signed [Q_W-1:0]       weight_reg;
    logic signed [Q_W-1:0]       delta_reg;
    logic                        sat_reg;
    logic                        wr_valid_reg;
    logic [ADDR_W-1:0]           wr_addr_reg;

    logic signed [2*Q_W-1:0]     g_prod;
    logic [2*Q_W-1:0]            ram_rdata;
    logic                        ram_we;
    logic signed [Q_W-1:0]       s1_w_old;
    logic signed [Q_W-1:0]       s1_d_old;
    logic                        s1_hit_wr;
    logic signed [A_PROD_W-1:0]  a_prod;
    logic                        s2_hit_s3;
    logic                        s2_hit_wr;
    logic signed [Q_W-1:0]       s2_d_base;
    logic signed [Q_W-1:0]       s2_w_base;
    logic signed [M_PROD_W-1:0]  m_prod;
    logic signed [M_W-1:0]       m_val;
    logic signed [SUM_W-1:0]     d_sum;
    sat_t                        d_clamp;
    logic signed [Q_W-1:0]       d_new;
    logic                        d_sat;
    logic                        s3_hit_wr;
    logic signed [Q_W-1:0]       s3_w_base;
    logic signed [SUM_W-1:0]     w_sum;
    sat_t                        w_clamp;
    logic signed [Q_W-1:0]       w_res;
    logic signed [Q_W-1:0]       d_res;
    logic                        sat_res;

    assign head_pop = head_valid;

    assign g_prod = head_item.source_output * head_item.gradient;

    mwu_ram #(
        .WIDTH (2 * Q_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s3_addr_reg),
        .wr_data ({w_res, d_res}),
        .rd_addr (head_addr),
        .rd_data (ram_rdata)
    );

    // the entry written at the same edge as the read is missed by the ram
    assign s1_hit_wr = wr_valid_reg && (wr_addr_reg == s1_addr_reg);
    assign s1_w_old  = s1_hit_wr ? weight_reg : ram_rdata[2*Q_W-1:Q_W];
    assign s1_d_old  = s1_hit_wr ? delta_reg  : ram_rdata[Q_W-1:0];
    assign a_prod    = A_PROD_W'(s1_g_reg) * A_PROD_W'($signed({1'b0, learn_rate}));

    // newest writer wins: stage 3, then the entry written last edge
    assign s2_hit_s3 = s3_valid_reg && s3_tag_reg.live && (s3_addr_reg == s2_addr_reg);
    assign s2_hit_wr = wr_valid_reg && (wr_addr_reg == s2_addr_reg);

    always_comb
    begin
        priority if (s2_hit_s3)
        begin
            s2_d_base = s3_d_reg;
        end
        else if (s2_hit_wr)
        begin
            s2_d_base = delta_reg;
        end
        else
        begin
            s2_d_base = s2_d_old_reg;
        end
    end

    assign s2_w_base = s2_hit_wr ? weight_reg : s2_w_old_reg;
    assign m_prod    = M_PROD_W'(s2_d_base) * M_PROD_W'($signed({1'b0, momentum}));
    assign m_val     = m_prod[M_PROD_W-1:FRAC];
    assign d_sum     = SUM_W'(s2_a_reg) + SUM_W'(m_val);
    assign d_clamp   = clamp16(d_sum);

    always_comb
    begin
        unique case (s2_tag_reg.op)
            OP_LOAD:
            begin
                d_new = '0;
                d_sat = 1'b0;
            end
            OP_UPDATE:
            begin
                d_new = d_clamp.value;
                d_sat = d_clamp.clamped;
            end
            default:
            begin
                d_new = '0;
                d_sat = 1'b0;
            end
        endcase
    end

    assign s3_hit_wr = wr_valid_reg && (wr_addr_reg == s3_addr_reg);
    assign s3_w_base = s3_hit_wr ? weight_reg : s3_w_old_reg;
    assign w_sum     = SUM_W'(s3_w_base) + SUM_W'(s3_d_reg);
    assign w_clamp   = clamp16(w_sum);

    always_comb
    begin
        priority if (!s3_tag_reg.live)
        begin
            w_res   = '0;
            d_res   = '0;
            sat_res = 1'b0;
        end
        else if (s3_tag_reg.op == OP_LOAD)
        begin
            w_res   = s3_tag_reg.load_value;
            d_res   = '0;
            sat_res = 1'b0;
        end
        else
        begin
            w_res   = w_clamp.value;
            d_res   = s3_d_reg;
            sat_res = s3_sat_reg || w_clamp.clamped;
        end
    end

    assign ram_we = s3_valid_reg && s3_tag_reg.live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= head_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
            wr_valid_reg <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg.op         <= head_item.op;
        s1_tag_reg.live       <= head_item.live;
        s1_tag_reg.load_value <= head_item.load_value;
        s1_addr_reg           <= head_addr;
        s1_g_reg              <= g_prod[2*Q_W-1:FRAC];

        s2_tag_reg   <= s1_tag_reg;
        s2_addr_reg  <= s1_addr_reg;
        s2_a_reg     <= a_prod[A_PROD_W-1:FRAC];
        s2_w_old_reg <= s1_w_old;
        s2_d_old_reg <= s1_d_old;

        s3_tag_reg   <= s2_tag_reg;
        s3_addr_reg  <= s2_addr_reg;
        s3_d_reg     <= d_new;
        s3_sat_reg   <= d_sat;
        s3_w_old_reg <= s2_w_base;

        weight_reg  <= w_res;
        delta_reg   <= d_res;
        sat_reg     <= sat_res;
        wr_addr_reg <= s3_addr_reg;
    end

    assign done       = done_reg;
    assign weight     = weight_reg;
    assign step_delta = delta_reg;
    assign saturated  = sat_reg;

`ifndef SYNTHESIS
    a_pop_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> ##4 done)
        else $error("popped request produced no result four cycles later");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_tag_reg.live && (s3_tag_reg.op == OP_LOAD)
        |=> done && (step_delta == '0) && !saturated)
        else $error("load result must carry zero delta and no saturation");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_tag_reg.live
        |=> done && (weight == '0) && (step_delta == '0) && !saturated && !wr_valid_reg)
        else $error("out-of-range request touched the array or gave a nonzero result");
`endif

endmodule

`default_nettype wire

/* src/momentum_weight_update.sv */
// momentum_weight_update: top level, configuration registers and front/queue/back wiring
// depends on mwu_pkg, mwu_front, mwu_queue, mwu_back (which holds mwu_ram)
`timescale 1ns / 1ps
`default_nettype none

// SGD-with-momentum weight update for one layer, one weight and one delta per connection.
// Request channel: a request is taken at a rising edge with start high and busy low.
//   op selects load (write weight, clear delta) or update
//   (delta = eta*output*gradient + alpha*old_delta, weight += delta, both saturated).
// Result channel: done is high for exactly one cycle with weight, step_delta and
//   saturated; the receiver cannot stall, so results are never held back.
// Configuration: cfg_write with cfg_index selects learn_rate or momentum; write only
//   while no request is in flight.
// Pipeline: a taken request passes the front register, the queue, the back end's stage
//   registers and the result register, where done is raised; one request per cycle is
//   sustained while busy is low, also to the same connection, since the delta and weight
//   read from the array are bypassed from the three newest writes.
// The loop that sets the rate is the delta recurrence: one 16x13 multiply, add and
//   clamp in a single stage.
// Reset clears the pipeline, queue and result strobe and loads learn_rate = 0.25 and
//   momentum = about 0.3; array contents are undefined until loaded.
// Connections with an index beyond MAX_SOURCES or MAX_DESTS return zeros and are not stored.

module momentum_weight_update #(
    parameter int MAX_SOURCES = 64,
    parameter int MAX_DESTS   = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [mwu_pkg::IDX_W-1:0]           src_index,
    input  logic [mwu_pkg::IDX_W-1:0]           dst_index,
    input  logic signed [mwu_pkg::Q_W-1:0]      source_output,
    input  logic signed [mwu_pkg::Q_W-1:0]      gradient,
    input  logic signed [mwu_pkg::Q_W-1:0]      load_value,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [mwu_pkg::CFG_W-1:0]           cfg_data,
    output logic                                done,
    output logic signed [mwu_pkg::Q_W-1:0]      weight,
    output logic signed [mwu_pkg::Q_W-1:0]      step_delta,
    output logic                                saturated
);

    import mwu_pkg::*;

    localparam int DEPTH  = MAX_SOURCES * MAX_DESTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int Q_DATA_W = ADDR_W + $bits(item_t);

    logic [CFG_W-1:0]    learn_rate_reg;
    logic [CFG_W-1:0]    momentum_reg;

    logic                push_valid;
    logic                push_ready;
    item_t               push_item;
    logic [ADDR_W-1:0]   push_addr;
    logic                head_valid;
    logic                head_pop;
    logic [Q_DATA_W-1:0] head_data;
    item_t               head_item;
    logic [ADDR_W-1:0]   head_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= LEARN_RATE_RESET;
            momentum_reg   <= MOMENTUM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_LEARN_RATE: learn_rate_reg <= cfg_data;
                CFG_MOMENTUM:   momentum_reg   <= cfg_data;
                default:        learn_rate_reg <= learn_rate_reg;
            endcase
        end
    end

    mwu_front #(
        .MAX_SOURCES (MAX_SOURCES),
        .MAX_DESTS   (MAX_DESTS),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .src_index     (src_index),
        .dst_index     (dst_index),
        .source_output (source_output),
        .gradient      (gradient),
        .load_value    (load_value),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item),
        .push_addr     (push_addr)
    );

    mwu_queue #(
        .WIDTH (Q_DATA_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_addr, push_item}),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_data   (head_data)
    );

    assign head_item = head_data[$bits(item_t)-1:0];
    assign head_addr = head_data[Q_DATA_W-1:$bits(item_t)];

    mwu_back #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .head_addr    (head_addr),
        .head_pop     (head_pop),
        .learn_rate   (learn_rate_reg),
        .momentum     (momentum_reg),
        .done         (done),
        .weight       (weight),
        .step_delta   (step_delta),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire
